/* rtl/rgtp_pkg.sv */
// rgtp_pkg: types, constants and color helpers for the rectangle grid test pattern
// no dependencies
`default_nettype none
package rgtp_pkg;

   localparam int RES_W          = 11;
   localparam int MAX_RESOLUTION = 2047;
   localparam int OFFSET_W       = 24;
   localparam int COLOR_W        = 32;
   localparam int COUNT_W        = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_RESOLUTION   = 3'd0,
      REG_Y_RESOLUTION   = 3'd1,
      REG_BITS_PER_PIXEL = 3'd2,
      REG_INDEXED_MODE   = 3'd3,
      REG_RECT_COUNT     = 3'd4,
      REG_FIRST_COLOR    = 3'd5,
      REG_COLOR_STEP     = 3'd6,
      REG_CHANNEL_LAYOUT = 3'd7
   } reg_index_type;

   // live configuration as seen by the datapath
   typedef struct packed {
      logic [RES_W-1:0] xres;
      logic [RES_W-1:0] yres;
      logic [5:0]       bpp;
      logic             indexed;
      logic [7:0]       count;
      logic [31:0]      first;
      logic [7:0]       step;
      logic [29:0]      layout;
   } cfg_type;

   // two restoring divisions that run side by side
   typedef struct packed {
      logic [1:0][RES_W-1:0] num;
      logic [1:0][RES_W-1:0] den;
      logic [1:0][RES_W-1:0] rem;
      logic [1:0][RES_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic [RES_W-1:0] x;
      logic [RES_W-1:0] y;
      logic [RES_W-1:0] w;
      logic [RES_W-1:0] h;
   } item_type;

   function automatic logic [31:0] low_mask(input logic [5:0] bits);
      logic [31:0] m;
      if (bits >= 6'd32) m = '1;
      else m = (32'd1 << bits) - 32'd1;
      return m;
   endfunction

   function automatic logic [31:0] channel(input logic [31:0] first, input logic [4:0] size,
                                          input logic [4:0] pos, input logic [31:0] adv);
      logic [31:0] m;
      logic [31:0] v;
      m = low_mask({1'b0, size});
      v = ((first >> pos) & m) + adv;
      return (v & m) << pos;
   endfunction

endpackage
`default_nettype wire

/* rtl/rgtp_if.sv */
// rgtp channel interfaces: pixel request, result and register write
// uses rgtp_pkg
`default_nettype none
interface rgtp_req_if import rgtp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] pixel_x;
   logic [RES_W-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface rgtp_rsp_if import rgtp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                write_enable;
   logic [OFFSET_W-1:0] byte_offset;
   logic [COUNT_W-1:0]  byte_count;
   logic [COLOR_W-1:0]  pixel_color;
   modport source (output valid, write_enable, byte_offset, byte_count, pixel_color,
                   input ready);
   modport sink (input valid, write_enable, byte_offset, byte_count, pixel_color,
                 output ready);
endinterface

interface rgtp_csr_if import rgtp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/rgtp_div_cell.sv */
// rgtp_div_cell: one restoring division step for two dividends, one bit per cell
// uses rgtp_pkg
`default_nettype none
module rgtp_div_cell import rgtp_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     in_valid,
   input  wire div_type  in_div,
   input  wire item_type in_item,
   output logic          out_valid,
   output div_type       out_div,
   output item_type      out_item
);
   logic     valid_ff;
   div_type  div_ff, div_in;
   item_type item_ff;
   logic [RES_W:0] trial;

   always_comb begin
      div_in = in_div;
      trial  = '0;
      for (int j = 0; j < 2; j++) begin
         trial = {in_div.rem[j], in_div.num[j][BIT]};
         if (trial >= {1'b0, in_div.den[j]}) begin
            trial              = trial - {1'b0, in_div.den[j]};
            div_in.quo[j][BIT] = 1'b1;
         end
         div_in.rem[j] = trial[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff  <= div_in;
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

/* rtl/rgtp_color.sv */
// rgtp_color: offset and color stages after the grid position is known
// uses rgtp_pkg
`default_nettype none
module rgtp_color import rgtp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire cfg_type          cfg,
   input  wire logic             in_valid,
   input  wire item_type         in_item,
   input  wire logic [RES_W-1:0] col,
   input  wire logic [RES_W-1:0] row,
   output logic                  out_valid,
   output logic                  out_we,
   output logic [OFFSET_W-1:0]   out_offset,
   output logic [COUNT_W-1:0]    out_count,
   output logic [COLOR_W-1:0]    out_color
);
   logic [5:0]         bpp;
   logic [COUNT_W-1:0] bytes;
   logic               we;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic we1_ff, we2_ff, we3_ff;
   logic [2*RES_W-1:0] yx1_ff, lin2_ff;
   logic [RES_W-1:0]   x1_ff;
   logic [16:0]        idx1_ff, idx2_ff;
   logic [7:0]         col1_ff;
   logic [15:0]        cs1_ff, cs2_ff, cs3_ff, rs1_ff, rs2_ff, rs3_ff;
   logic [16:0]        crs1_ff, crs2_ff, crs3_ff;
   logic [OFFSET_W-1:0] off3_ff;
   logic [24:0]        idxs3_ff;
   logic               we4_ff;
   logic [OFFSET_W-1:0] off4_ff;
   logic [COLOR_W-1:0] color4_ff, color_in;
   logic [24:0]        off_full;

   always_comb begin
      if (cfg.bpp == 6'd0) bpp = 6'd1;
      else if (cfg.bpp > 6'd32) bpp = 6'd32;
      else bpp = cfg.bpp;
      bytes = COUNT_W'((bpp + 6'd7) >> 3);
   end

   assign we = (cfg.count != 8'd0) && (in_item.x < cfg.xres) && (in_item.y < cfg.yres)
               && (in_item.w != '0) && (in_item.h != '0)
               && (col < {3'd0, cfg.count}) && (row < {3'd0, cfg.count});

   assign off_full = 25'(lin2_ff) * 25'(bytes);

   always_comb begin
      if (cfg.indexed) begin
         color_in = (cfg.first + 32'(idxs3_ff)) & low_mask(bpp);
      end else begin
         color_in = channel(cfg.first, cfg.layout[29:25], cfg.layout[24:20], 32'(cs3_ff))
                  | channel(cfg.first, cfg.layout[19:15], cfg.layout[14:10], 32'(rs3_ff))
                  | channel(cfg.first, cfg.layout[9:5], cfg.layout[4:0], 32'(crs3_ff));
      end
      if (!we3_ff) color_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // multiplies first, sums next, then scaling, color last
         we1_ff  <= we;
         x1_ff   <= in_item.x;
         yx1_ff  <= in_item.y * cfg.xres;
         col1_ff <= col[7:0];
         idx1_ff <= 17'(row[7:0] * cfg.count);
         cs1_ff  <= col[7:0] * cfg.step;
         rs1_ff  <= row[7:0] * cfg.step;
         crs1_ff <= ({1'b0, col[7:0]} + {1'b0, row[7:0]}) * cfg.step;

         we2_ff  <= we1_ff;
         lin2_ff <= yx1_ff + (2*RES_W)'(x1_ff);
         idx2_ff <= idx1_ff + 17'(col1_ff);
         cs2_ff  <= cs1_ff;
         rs2_ff  <= rs1_ff;
         crs2_ff <= crs1_ff;

         we3_ff   <= we2_ff;
         off3_ff  <= we2_ff ? off_full[OFFSET_W-1:0] : '0;
         idxs3_ff <= 25'(idx2_ff * cfg.step);
         cs3_ff   <= cs2_ff;
         rs3_ff   <= rs2_ff;
         crs3_ff  <= crs2_ff;

         we4_ff    <= we3_ff;
         off4_ff   <= off3_ff;
         color4_ff <= color_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_we     = we4_ff;
   assign out_offset = off4_ff;
   assign out_count  = bytes;
   assign out_color  = color4_ff;
endmodule
`default_nettype wire

/* rtl/rectangle_grid_test_pattern_top.sv */
// rectangle_grid_test_pattern_top: 22 division cells, then 4 color stages
// throughput one pixel per cycle; the whole chain holds only when the result is stalled
// synchronous active-high reset clears the pipeline valids and loads register defaults
// uses rgtp_pkg, rgtp_if, rgtp_div_cell, rgtp_color
`default_nettype none
module rectangle_grid_test_pattern_top import rgtp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rgtp_req_if.sink   req_bus,
   rgtp_rsp_if.source rsp_bus,
   rgtp_csr_if.sink   csr_bus
);
   logic [RES_W-1:0] xres_ff, yres_ff;
   logic [5:0]       bpp_ff;
   logic             indexed_ff;
   logic [7:0]       count_ff;
   logic [31:0]      first_ff;
   logic [7:0]       step_ff;
   logic [29:0]      layout_ff;
   cfg_type          cfg;
   logic             advance;

   logic     a_valid [RES_W+1];
   div_type  a_div   [RES_W+1];
   item_type a_item  [RES_W+1];
   logic     b_valid [RES_W+1];
   div_type  b_div   [RES_W+1];
   item_type b_item  [RES_W+1];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xres_ff    <= 11'd1024;
         yres_ff    <= 11'd768;
         bpp_ff     <= 6'd8;
         indexed_ff <= 1'b1;
         count_ff   <= 8'd1;
         first_ff   <= 32'd0;
         step_ff    <= 8'd1;
         layout_ff  <= 30'd285483264;
      end else if (csr_bus.valid) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_X_RESOLUTION:   xres_ff    <= csr_bus.data[RES_W-1:0];
            REG_Y_RESOLUTION:   yres_ff    <= csr_bus.data[RES_W-1:0];
            REG_BITS_PER_PIXEL: bpp_ff     <= csr_bus.data[5:0];
            REG_INDEXED_MODE:   indexed_ff <= csr_bus.data[0];
            REG_RECT_COUNT:     count_ff   <= csr_bus.data[7:0];
            REG_FIRST_COLOR:    first_ff   <= csr_bus.data;
            REG_COLOR_STEP:     step_ff    <= csr_bus.data[7:0];
            REG_CHANNEL_LAYOUT: layout_ff  <= csr_bus.data[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.xres    = (32'(xres_ff) > MAX_RESOLUTION) ? RES_W'(MAX_RESOLUTION) : xres_ff;
      cfg.yres    = (32'(yres_ff) > MAX_RESOLUTION) ? RES_W'(MAX_RESOLUTION) : yres_ff;
      cfg.bpp     = bpp_ff;
      cfg.indexed = indexed_ff;
      cfg.count   = count_ff;
      cfg.first   = first_ff;
      cfg.step    = step_ff;
      cfg.layout  = layout_ff;
   end

   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // first chain: rectangle width and height
   always_comb begin
      a_valid[0]       = req_bus.valid;
      a_div[0]         = '0;
      a_div[0].num[0]  = cfg.xres;
      a_div[0].num[1]  = cfg.yres;
      a_div[0].den[0]  = RES_W'(cfg.count);
      a_div[0].den[1]  = RES_W'(cfg.count);
      a_item[0]        = '0;
      a_item[0].x      = req_bus.pixel_x;
      a_item[0].y      = req_bus.pixel_y;
   end

   // second chain: column and row of the pixel
   always_comb begin
      b_valid[0]      = a_valid[RES_W];
      b_div[0]        = '0;
      b_div[0].num[0] = a_item[RES_W].x;
      b_div[0].num[1] = a_item[RES_W].y;
      b_div[0].den[0] = a_div[RES_W].quo[0];
      b_div[0].den[1] = a_div[RES_W].quo[1];
      b_item[0]       = a_item[RES_W];
      b_item[0].w     = a_div[RES_W].quo[0];
      b_item[0].h     = a_div[RES_W].quo[1];
   end

   for (genvar k = 0; k < RES_W; k++) begin : g_cells
      rgtp_div_cell #(.BIT(RES_W-1-k)) u_size_cell (
         .clock, .reset, .advance,
         .in_valid (a_valid[k]),   .in_div (a_div[k]),   .in_item (a_item[k]),
         .out_valid(a_valid[k+1]), .out_div(a_div[k+1]), .out_item(a_item[k+1])
      );
      rgtp_div_cell #(.BIT(RES_W-1-k)) u_pos_cell (
         .clock, .reset, .advance,
         .in_valid (b_valid[k]),   .in_div (b_div[k]),   .in_item (b_item[k]),
         .out_valid(b_valid[k+1]), .out_div(b_div[k+1]), .out_item(b_item[k+1])
      );
   end

   rgtp_color u_color (
      .clock, .reset, .advance, .cfg,
      .in_valid  (b_valid[RES_W]),
      .in_item   (b_item[RES_W]),
      .col       (b_div[RES_W].quo[0]),
      .row       (b_div[RES_W].quo[1]),
      .out_valid (rsp_bus.valid),
      .out_we    (rsp_bus.write_enable),
      .out_offset(rsp_bus.byte_offset),
      .out_count (rsp_bus.byte_count),
      .out_color (rsp_bus.pixel_color)
   );
endmodule
`default_nettype wire

/* rtl/rgtp_checker.sv */
// rgtp_assert: port-level checks on the result channel, bound to the top level
// uses rgtp_pkg widths
`default_nettype none
module rgtp_assert import rgtp_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_we,
   input wire logic [OFFSET_W-1:0] rsp_offset,
   input wire logic [COUNT_W-1:0]  rsp_count,
   input wire logic [COLOR_W-1:0]  rsp_color
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_offset) && $stable(rsp_color) && $stable(rsp_we))
      else $error("result changed while stalled");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_we |-> rsp_offset == '0 && rsp_color == '0)
      else $error("skipped pixel carries data");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != '0 && rsp_count <= 3'd4)
      else $error("byte count out of range");

   // first edge after reset is released: the pipeline must still be empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result right after reset");
endmodule

bind rectangle_grid_test_pattern_top rgtp_assert u_rgtp_assert (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_we    (rsp_bus.write_enable),
   .rsp_offset(rsp_bus.byte_offset),
   .rsp_count (rsp_bus.byte_count),
   .rsp_color (rsp_bus.pixel_color)
);
`default_nettype wire

/* tb/rgtp_checker.sv */
`timescale 1ns / 100ps
// rgtp_checker: tracks register writes, predicts each pixel result and compares it with the block
// uses rgtp_pkg and the channel interfaces of rgtp_if
`default_nettype none
module rgtp_checker import rgtp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rgtp_req_if      req_bus,
   rgtp_rsp_if      rsp_bus,
   rgtp_csr_if      csr_bus,
   output int       fail_count,
   output int       pending,
   output int       checked_count,
   output int       written_count
);

   typedef struct {
      logic                write_enable;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COUNT_W-1:0]  byte_count;
      logic [COLOR_W-1:0]  pixel_color;
   } pixel_result_t;

   logic [RES_W-1:0] xres_q, yres_q;
   logic [5:0]       bpp_q;
   logic             indexed_q;
   logic [7:0]       count_q;
   logic [31:0]      first_q;
   logic [7:0]       step_q;
   logic [29:0]      layout_q;

   pixel_result_t expected_results[$];
   int            mismatches;

   function automatic longint unsigned ones_below(int unsigned bits);
      if (bits >= 64) return '1;
      return (64'd1 << bits) - 64'd1;
   endfunction

   function automatic longint unsigned rgb_field(int unsigned size, int unsigned pos,
                                                 longint unsigned adv);
      longint unsigned m, v;
      m = ones_below(size);
      v = ((longint'(first_q) >> pos) & m) + adv;
      return ((v & m) << pos) & 64'hFFFF_FFFF;
   endfunction

   function automatic pixel_result_t grid_pixel(logic [RES_W-1:0] x, logic [RES_W-1:0] y);
      int unsigned     xres, yres, n, bpp, nbytes, w, h, col, row;
      longint unsigned colr, off, stp;
      pixel_result_t   r;
      xres = (xres_q > MAX_RESOLUTION) ? MAX_RESOLUTION : xres_q;
      yres = (yres_q > MAX_RESOLUTION) ? MAX_RESOLUTION : yres_q;
      n = count_q;
      bpp = bpp_q;
      if (bpp == 0) bpp = 1;
      if (bpp > 32) bpp = 32;
      nbytes = (bpp + 7) / 8;
      colr = 0;
      off = 0;
      r.write_enable = 1'b0;
      stp = step_q;
      if (n != 0 && x < xres && y < yres) begin
         w = xres / n;
         h = yres / n;
         if (w != 0 && h != 0) begin
            col = x / w;
            row = y / h;
            if (col < n && row < n) begin
               r.write_enable = 1'b1;
               off = (longint'(y) * xres + x) * nbytes;
               if (indexed_q) begin
                  colr = (longint'(first_q) + (longint'(row) * n + col) * stp) & ones_below(bpp);
               end else begin
                  colr = rgb_field(layout_q[29:25], layout_q[24:20], col * stp)
                       | rgb_field(layout_q[19:15], layout_q[14:10], row * stp)
                       | rgb_field(layout_q[9:5], layout_q[4:0], (longint'(col) + row) * stp);
               end
            end
         end
      end
      r.byte_offset = off[OFFSET_W-1:0];
      r.byte_count = nbytes[COUNT_W-1:0];
      r.pixel_color = colr[COLOR_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         xres_q <= 11'd1024;
         yres_q <= 11'd768;
         bpp_q <= 6'd8;
         indexed_q <= 1'b1;
         count_q <= 8'd1;
         first_q <= 32'd0;
         step_q <= 8'd1;
         layout_q <= 30'd285483264;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (reg_index_type'(csr_bus.index))
            REG_X_RESOLUTION:   xres_q <= csr_bus.data[RES_W-1:0];
            REG_Y_RESOLUTION:   yres_q <= csr_bus.data[RES_W-1:0];
            REG_BITS_PER_PIXEL: bpp_q <= csr_bus.data[5:0];
            REG_INDEXED_MODE:   indexed_q <= csr_bus.data[0];
            REG_RECT_COUNT:     count_q <= csr_bus.data[7:0];
            REG_FIRST_COLOR:    first_q <= csr_bus.data;
            REG_COLOR_STEP:     step_q <= csr_bus.data[7:0];
            REG_CHANNEL_LAYOUT: layout_q <= csr_bus.data[29:0];
            default: ;
         endcase
      end
   end

   initial begin
      fail_count = 0;
      mismatches = 0;
      checked_count = 0;
      written_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      pixel_result_t e;
      if (!reset) begin
         // pop before push so a pixel taken this edge is never compared this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
               e = expected_results.pop_front();
               checked_count++;
               if (rsp_bus.write_enable) written_count++;
               if (rsp_bus.write_enable !== e.write_enable ||
                   rsp_bus.byte_offset !== e.byte_offset ||
                   rsp_bus.byte_count !== e.byte_count ||
                   rsp_bus.pixel_color !== e.pixel_color) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch we/off/cnt/color exp %b %h %0d %h got %b %h %0d %h",
                              $realtime, e.write_enable, e.byte_offset, e.byte_count,
                              e.pixel_color, rsp_bus.write_enable, rsp_bus.byte_offset,
                              rsp_bus.byte_count, rsp_bus.pixel_color);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(grid_pixel(req_bus.pixel_x, req_bus.pixel_y));
         pending = expected_results.size();
      end
   end

endmodule
`default_nettype wire

/* tb/rectangle_grid_test_pattern_top_tb.sv */
`timescale 1ns / 100ps
// rectangle_grid_test_pattern_top_tb: pixel and register stimulus with random stalls, verdict
// uses rgtp_pkg, rgtp_if, rgtp_checker and the block rectangle_grid_test_pattern_top
`default_nettype none
module rectangle_grid_test_pattern_top_tb;
   import rgtp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, checked_count, written_count;
   logic req_taken = 1'b0, csr_taken = 1'b0;
   logic gaps_on = 1'b1;
   int   stall_left = 0;
   int   phase_count = 0;

   rgtp_req_if req_bus();
   rgtp_rsp_if rsp_bus();
   rgtp_csr_if csr_bus();

   rectangle_grid_test_pattern_top u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   rgtp_checker u_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus),
      .fail_count(fail_count), .pending(pending), .checked_count(checked_count),
      .written_count(written_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer flags, read back at the following falling edge
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
      csr_taken <= csr_bus.valid && csr_bus.ready;
   end

   // result-side stalls in random bursts
   always @(negedge clock) begin
      if (!gaps_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_pixel(input logic [RES_W-1:0] x, input logic [RES_W-1:0] y);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_x <= x;
      req_bus.pixel_y <= y;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(negedge clock); while (!csr_taken);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // idle point: every result back plus the pipeline depth
   task automatic drain;
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic load_grid(input int xres, input int yres, input int bpp, input int indexed,
                            input int n, input logic [31:0] first, input int step,
                            input logic [29:0] layout);
      drain();
      write_reg(REG_X_RESOLUTION, xres);
      write_reg(REG_Y_RESOLUTION, yres);
      write_reg(REG_BITS_PER_PIXEL, bpp);
      write_reg(REG_INDEXED_MODE, indexed);
      write_reg(REG_RECT_COUNT, n);
      write_reg(REG_FIRST_COLOR, first);
      write_reg(REG_COLOR_STEP, step);
      write_reg(REG_CHANNEL_LAYOUT, {2'b00, layout});
      phase_count++;
   endtask

   task automatic random_phase(input int items);
      int xres, yres, bpp, n, sel;
      xres = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 300);
      yres = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 300);
      sel = $urandom_range(0, 9);
      bpp = (sel == 0) ? 0 : (sel == 1) ? 63 : (sel == 2) ? 32 : $urandom_range(8, 32);
      sel = $urandom_range(0, 9);
      n = (sel == 0) ? 0 : (sel == 1) ? 255 : (sel == 2) ? 1 : $urandom_range(1, 12);
      load_grid(xres, yres, bpp, $urandom_range(0, 1), n, $urandom(), $urandom_range(0, 255),
                ($urandom_range(0, 1)) ? 30'($urandom()) : 30'd285483264);
      repeat (items) begin
         if ($urandom_range(0, 7) == 0)
            send_pixel(RES_W'($urandom_range(0, 2047)), RES_W'($urandom_range(0, 2047)));
         else
            send_pixel(RES_W'($urandom_range(0, xres - 1)),
                       RES_W'($urandom_range(0, yres - 1)));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_X_RESOLUTION;
      csr_bus.data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // default registers: corners, just outside the screen, far corner of the field range
      send_pixel(0, 0);
      send_pixel(1023, 767);
      send_pixel(1024, 0);
      send_pixel(0, 768);
      send_pixel(2047, 2047);
      // 3x3 grid on 10x10: leftover stripe at x or y 9
      load_grid(10, 10, 8, 1, 3, 32'd250, 7, 30'd285483264);
      send_pixel(4, 4);
      send_pixel(9, 0);
      send_pixel(0, 9);
      send_pixel(8, 8);
      // more rectangles than pixels, and no rectangles at all
      load_grid(4, 100, 0, 1, 5, 32'hFFFF_FFFF, 255, 30'd0);
      send_pixel(1, 1);
      load_grid(2047, 2047, 63, 1, 0, 32'hFFFF_FFFF, 255, 30'd0);
      send_pixel(5, 5);
      // max resolution, widest pixel, largest grid
      load_grid(2047, 2047, 63, 1, 255, 32'hFFFF_FFFF, 255, 30'd0);
      send_pixel(2046, 2046);
      send_pixel(2040, 0);
      // direct color: zero-size field, field past bit 31, color wider than bpp
      load_grid(2047, 2047, 8, 0, 255, 32'hFFFF_FFFF, 255,
                {5'd0, 5'd3, 5'd16, 5'd31, 5'd31, 5'd20});
      send_pixel(2039, 2039);
      send_pixel(0, 0);
      send_pixel(1024, 17);
      load_grid(1, 1, 24, 0, 1, 32'h00A5_5A3C, 0, 30'h3FFF_FFFF);
      send_pixel(0, 0);
      send_pixel(1, 0);

      repeat (9) random_phase(110);
      gaps_on = 1'b0;
      random_phase(110);
      drain();

      $display("checked %0d pixel results (%0d written) over %0d register settings",
               checked_count, written_count, phase_count + 1);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
